@@ sv/pru_pkg.sv @@
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants for the PNG row unfilter core.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int MAX_ROW_BYTES = 8192;
  localparam int ADDR_W        = $clog2(MAX_ROW_BYTES);
  localparam int STRIDE_W      = $clog2(MAX_ROW_BYTES + 1);
  localparam int ROWPIX_W      = 13;
  localparam int WIDE_W        = (STRIDE_W > ROWPIX_W) ? STRIDE_W : ROWPIX_W;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam logic REG_SIXTEEN_BIT = 1'b0;
  localparam logic REG_ROW_PIXELS  = 1'b1;

  // filter types
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       bad_filter;
  } out_t;

  typedef enum logic [1:0] {
    CMD_FILTER,
    CMD_PIXEL,
    CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [ADDR_W-1:0] x;
    logic              slot;
    logic              first_row;
    logic [2:0]        filt;
    logic              emit;
    logic              last;
  } cmd_t;

endpackage

@@ sv/pru_ram.sv @@
// ----------------------------------------------------------------------------
// pru_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/pru_front.sv @@
// ----------------------------------------------------------------------------
// pru_front
// Accepts stream bytes, tracks row framing and the error latch, and turns
// each byte into a command for the back end (or drops it).
// ----------------------------------------------------------------------------
module pru_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sixteen_bit,
  input  logic [pru_pkg::ROWPIX_W-1:0] row_pixels,
  input  logic                         src_valid,
  output logic                         src_ready,
  input  pru_pkg::in_t                 src_data,
  input  logic                         q_full,
  output logic                         push,
  output pru_pkg::cmd_t                push_cmd
);
  import pru_pkg::*;

  logic              awaiting, awaiting_next;
  logic              first_row, first_row_next;
  logic              err, err_next;
  logic [ADDR_W-1:0] pos, pos_next;
  logic [2:0]        filt, filt_next;

  logic                aw_e, first_e, err_e;
  logic [ADDR_W-1:0]   pos_e;
  logic [WIDE_W-1:0]   pix, cap;
  logic [STRIDE_W-1:0] stride, x_inc, x_bpp;
  logic                accept;

  // row length in bytes, pixel count saturated to the line store
  always_comb begin
    pix = (row_pixels == '0) ? WIDE_W'(1) : WIDE_W'(row_pixels);
    cap = sixteen_bit ? WIDE_W'(MAX_ROW_BYTES / 2) : WIDE_W'(MAX_ROW_BYTES);
    if (pix > cap) begin
      pix = cap;
    end
    stride = sixteen_bit ? STRIDE_W'({pix, 1'b0}) : STRIDE_W'(pix);
  end

  assign src_ready = !q_full;
  assign accept    = src_valid && src_ready;

  always_comb begin
    aw_e    = src_data.frame_start || awaiting;
    first_e = src_data.frame_start || first_row;
    err_e   = !src_data.frame_start && err;
    pos_e   = src_data.frame_start ? '0 : pos;
    x_inc   = STRIDE_W'(pos_e) + STRIDE_W'(1);
    x_bpp   = STRIDE_W'(pos_e) + (sixteen_bit ? STRIDE_W'(2) : STRIDE_W'(1));

    awaiting_next  = awaiting;
    first_row_next = first_row;
    err_next       = err;
    pos_next       = pos;
    filt_next      = filt;
    push           = 1'b0;

    push_cmd.kind      = CMD_PIXEL;
    push_cmd.data      = src_data.data_byte;
    push_cmd.x         = pos_e;
    push_cmd.slot      = sixteen_bit && pos_e[0];
    push_cmd.first_row = first_e;
    push_cmd.filt      = filt;
    push_cmd.emit      = !sixteen_bit || !pos_e[0];
    push_cmd.last      = (x_bpp >= stride);

    if (accept) begin
      awaiting_next  = aw_e;
      first_row_next = first_e;
      err_next       = err_e;
      pos_next       = pos_e;
      if (err_e) begin
        // dropped until next frame start
      end else if (aw_e) begin
        push = 1'b1;
        if (src_data.data_byte > 8'(FILT_PAETH)) begin
          err_next      = 1'b1;
          push_cmd.kind = CMD_ERROR;
        end else begin
          filt_next     = src_data.data_byte[2:0];
          awaiting_next = 1'b0;
          pos_next      = '0;
          push_cmd.kind = CMD_FILTER;
        end
      end else begin
        push = 1'b1;
        if (x_inc >= stride) begin
          awaiting_next  = 1'b1;
          first_row_next = 1'b0;
          pos_next       = '0;
        end else begin
          pos_next = ADDR_W'(x_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting  <= 1'b1;
      first_row <= 1'b1;
      err       <= 1'b0;
      pos       <= '0;
      filt      <= FILT_NONE;
    end else begin
      awaiting  <= awaiting_next;
      first_row <= first_row_next;
      err       <= err_next;
      pos       <= pos_next;
      filt      <= filt_next;
    end
  end

endmodule

@@ sv/pru_fifo.sv @@
// ----------------------------------------------------------------------------
// pru_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pru_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pru_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pru_pkg::cmd_t head_cmd
);
  import pru_pkg::*;

  cmd_t                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full       = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/pru_back.sv @@
// ----------------------------------------------------------------------------
// pru_back
// Executes commands: reads the prior row, undoes the filter, writes the
// line store back and presents results in an output register.
// ----------------------------------------------------------------------------
module pru_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  pru_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          pix_valid,
  input  logic          pix_ready,
  output pru_pkg::out_t pix_data
);
  import pru_pkg::*;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [8:0] ab, c2;
    logic [8:0] pa, pb, pc;
    ab = {1'b0, a} + {1'b0, b};
    c2 = {c, 1'b0};
    pa = (b > c) ? 9'(b - c) : 9'(c - b);
    pb = (a > c) ? 9'(a - c) : 9'(c - a);
    pc = (ab > c2) ? (ab - c2) : (c2 - ab);
    if (pa <= pb && pa <= pc) begin
      return a;
    end
    return (pb <= pc) ? b : c;
  endfunction

  logic              r_valid;
  cmd_t              r_cmd;
  logic              byp;
  logic [7:0]        byp_data;
  logic [7:0]        rd_data;
  logic [7:0]        left [2];
  logic [7:0]        upleft [2];

  logic              e_emit, e_go, o_free, we;
  logic [7:0]        a, b, c, v;
  logic [8:0]        avg_sum;

  assign e_emit = (r_cmd.kind == CMD_ERROR) || ((r_cmd.kind == CMD_PIXEL) && r_cmd.emit);
  assign o_free = !pix_valid || pix_ready;
  assign e_go   = r_valid && (!e_emit || o_free);
  assign pop    = head_valid && (!r_valid || e_go);
  assign we     = e_go && (r_cmd.kind == CMD_PIXEL);

  pru_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line (
    .clk   (clk),
    .we    (we),
    .waddr (r_cmd.x),
    .wdata (v),
    .re    (pop),
    .raddr (head_cmd.x),
    .rdata (rd_data)
  );

  always_comb begin
    a       = left[r_cmd.slot];
    c       = upleft[r_cmd.slot];
    b       = r_cmd.first_row ? 8'd0 : (byp ? byp_data : rd_data);
    avg_sum = {1'b0, a} + {1'b0, b};
    case (r_cmd.filt)
      FILT_SUB:   v = r_cmd.data + a;
      FILT_UP:    v = r_cmd.data + b;
      FILT_AVG:   v = r_cmd.data + avg_sum[8:1];
      FILT_PAETH: v = r_cmd.data + paeth(a, b, c);
      default:    v = r_cmd.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_cmd <= head_cmd;
      // write landing on the address being read this edge
      byp      <= we && (r_cmd.x == head_cmd.x);
      byp_data <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (pop) begin
      r_valid <= 1'b1;
    end else if (e_go) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left[0]   <= '0;
      left[1]   <= '0;
      upleft[0] <= '0;
      upleft[1] <= '0;
    end else if (e_go) begin
      if (r_cmd.kind == CMD_FILTER) begin
        left[0]   <= '0;
        left[1]   <= '0;
        upleft[0] <= '0;
        upleft[1] <= '0;
      end else if (r_cmd.kind == CMD_PIXEL) begin
        left[r_cmd.slot]   <= v;
        upleft[r_cmd.slot] <= b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (e_go && e_emit) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_go && e_emit) begin
      if (r_cmd.kind == CMD_ERROR) begin
        pix_data.pixel      <= '0;
        pix_data.row_end    <= 1'b0;
        pix_data.bad_filter <= 1'b1;
      end else begin
        pix_data.pixel      <= v;
        pix_data.row_end    <= r_cmd.last;
        pix_data.bad_filter <= 1'b0;
      end
    end
  end

endmodule

@@ sv/png_row_unfilter_core.sv @@
// ----------------------------------------------------------------------------
// png_row_unfilter_core
// PNG grayscale scanline unfilter, one stream byte per request.
// ----------------------------------------------------------------------------
// Path: a pixel request goes through the queue, command and output registers.
// Throughput: one byte per cycle unless pix_ready stalls, set by the filter
// stage feeding the left-byte registers and the one-read one-write line store.
// Reset (synchronous): row framing, error latch, queue and output cleared;
// sixteen_bit = 0, row_pixels = 640. The line store needs no clearing pass.
// ----------------------------------------------------------------------------
module png_row_unfilter_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         src_valid,
  output logic                         src_ready,
  input  pru_pkg::in_t                 src_data,
  output logic                         pix_valid,
  input  logic                         pix_ready,
  output pru_pkg::out_t                pix_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [pru_pkg::ROWPIX_W-1:0] cfg_data
);
  import pru_pkg::*;

  logic                sixteen_bit;
  logic [ROWPIX_W-1:0] row_pixels;
  logic                push, q_full, pop, head_valid;
  cmd_t                push_cmd, head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sixteen_bit <= 1'b0;
      row_pixels  <= ROWPIX_W'(640);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIXTEEN_BIT: sixteen_bit <= cfg_data[0];
        REG_ROW_PIXELS:  row_pixels  <= cfg_data;
        default: ;
      endcase
    end
  end

  pru_front u_front (
    .clk         (clk),
    .rst         (rst),
    .sixteen_bit (sixteen_bit),
    .row_pixels  (row_pixels),
    .src_valid   (src_valid),
    .src_ready   (src_ready),
    .src_data    (src_data),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  pru_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  pru_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix_data   (pix_data)
  );

endmodule

@@ sv/pru_checker.sv @@
// ----------------------------------------------------------------------------
// pru_checker
// Port-level checks on the unfilter core, bound to the top level.
// ----------------------------------------------------------------------------
module pru_checker (
  input logic          clk,
  input logic          rst,
  input logic          src_valid,
  input logic          src_ready,
  input pru_pkg::in_t  src_data,
  input logic          pix_valid,
  input logic          pix_ready,
  input pru_pkg::out_t pix_data
);
  import pru_pkg::*;

  // an error result carries no pixel and never closes a row
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_data.bad_filter |-> pix_data.pixel == '0 && !pix_data.row_end)
    else $error("bad_filter result with pixel or row_end set");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pix_data))
    else $error("result changed while stalled");

  // nothing comes out the cycle after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("result valid straight after reset");

  // a byte taken at the first edge out of reset is still short of the output register when pix_valid is checked
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && !rst |-> ##1 !pix_valid)
    else $error("result appeared too soon after reset");

endmodule

bind png_row_unfilter_core pru_checker u_checker (.*);
